>>> src/biou_pkg.sv
// Package: shared widths, types and constants of the box IoU scorer.
package biou_pkg;
	localparam int COORD_BITS = 13;
	localparam int SIZE_BITS  = 12;
	localparam int FRAC_BITS  = 16;
	localparam int AREA_BITS  = 25;
	localparam int PROD_BITS  = 2 * SIZE_BITS;
	localparam int BS_BITS    = AREA_BITS + 1;
	localparam int DIV_BITS   = 2 * BS_BITS + 2;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int EDGE_BITS  = COORD_BITS + 2;
	localparam int LANES      = 2;
	localparam int LANE_PLAIN = 0;
	localparam int LANE_UNB   = 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SIZE_BITS-1:0]         dim_t;
	typedef logic [QUO_BITS-1:0]          score_t;
	typedef logic [AREA_BITS-1:0]         area_t;
	typedef logic signed [EDGE_BITS-1:0]  edge_t;
endpackage

>>> src/biou_if.sv
// Interfaces: box-pair request channel and score result channel.
interface biou_box_if;
	logic             valid;
	logic             ready;
	biou_pkg::coord_t annot_x;
	biou_pkg::coord_t annot_y;
	biou_pkg::dim_t   annot_w;
	biou_pkg::dim_t   annot_h;
	biou_pkg::coord_t track_x;
	biou_pkg::coord_t track_y;
	biou_pkg::dim_t   track_w;
	biou_pkg::dim_t   track_h;
	logic             track_failed;
	modport source (output valid, annot_x, annot_y, annot_w, annot_h, track_x, track_y,
		track_w, track_h, track_failed, input ready);
	modport sink (input valid, annot_x, annot_y, annot_w, annot_h, track_x, track_y,
		track_w, track_h, track_failed, output ready);
endinterface

interface biou_score_if;
	logic             valid;
	logic             ready;
	biou_pkg::score_t plain_iou;
	biou_pkg::score_t unbiased_iou;
	logic             no_overlap;
	modport source (output valid, plain_iou, unbiased_iou, no_overlap, input ready);
	modport sink (input valid, plain_iou, unbiased_iou, no_overlap, output ready);
endinterface

>>> src/box_iou_unbiased_metric.sv
// Top level: pipelined plain and unbiased IoU scorer for box pairs.
//
//  channel   | dir | handshake     | content
//  boxes     | in  | valid/ready   | annotated box, tracked box, tracking-failed flag
//  scores    | out | valid/ready   | plain_iou, unbiased_iou (Q1.16), no_overlap
//  cfg       | in  | cfg_wr_en     | frame_area (25 bits)
//
// One request per cycle while the output is not stalled; geometry, products and
// sums stages come first, then restoring division stages, one quotient bit per stage.
// arst_n clears all valid bits and frame_area; payload registers are not reset.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module box_iou_unbiased_metric (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_wr_en,
	input logic [biou_pkg::AREA_BITS-1:0] cfg_wr_data,
	biou_box_if.sink             boxes,
	biou_score_if.source         scores
);
	localparam int AW = biou_pkg::AREA_BITS;
	localparam int PW = biou_pkg::PROD_BITS;
	localparam int BW = biou_pkg::BS_BITS;
	localparam int DW = biou_pkg::DIV_BITS;
	localparam int QW = biou_pkg::QUO_BITS;
	localparam int SW = biou_pkg::SIZE_BITS;
	localparam int EW = biou_pkg::EDGE_BITS;
	localparam int NS = biou_pkg::DIV_STEPS;
	localparam int NL = biou_pkg::LANES;

	logic [AW-1:0] frame_area_q;
	logic          en;

	// Hold the frame area register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_area_q <= '0;
		end else if (cfg_wr_en) begin
			frame_area_q <= cfg_wr_data;
		end
	end

	// Advance the whole pipe unless the result stage is stalled
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [NS-1:0] vld_sd;
	assign en = !vld_sd[NS-1] || scores.ready;
	assign boxes.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_sd <= '0;
		end else if (en) begin
			vld_s1 <= boxes.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_sd <= {vld_sd[NS-2:0], vld_s7};
		end
	end

	// Stage 1: intersect edges
	biou_pkg::edge_t ax, ay, tx, ty, ax1, ay1, tx1, ty1, ex, ey;
	always_comb begin
		ax  = EW'(boxes.annot_x);
		ay  = EW'(boxes.annot_y);
		tx  = EW'(boxes.track_x);
		ty  = EW'(boxes.track_y);
		ax1 = ax + $signed({3'b000, boxes.annot_w});
		ay1 = ay + $signed({3'b000, boxes.annot_h});
		tx1 = tx + $signed({3'b000, boxes.track_w});
		ty1 = ty + $signed({3'b000, boxes.track_h});
		ex  = ((ax1 < tx1) ? ax1 : tx1) - ((ax > tx) ? ax : tx);
		ey  = ((ay1 < ty1) ? ay1 : ty1) - ((ay > ty) ? ay : ty);
	end

	logic [SW-1:0] ew_s1, eh_s1, aw_s1, ah_s1, tw_s1, th_s1;
	logic          fail_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ew_s1   <= (ex > 0) ? ex[SW-1:0] : '0;
			eh_s1   <= (ey > 0) ? ey[SW-1:0] : '0;
			aw_s1   <= boxes.annot_w;
			ah_s1   <= boxes.annot_h;
			tw_s1   <= boxes.track_w;
			th_s1   <= boxes.track_h;
			fail_s1 <= boxes.track_failed;
		end
	end

	// Stage 2: areas
	logic [PW-1:0] inter_s2, area_a_s2, area_t_s2;
	logic          fail_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			inter_s2  <= ew_s1 * eh_s1;
			area_a_s2 <= aw_s1 * ah_s1;
			area_t_s2 <= tw_s1 * th_s1;
			fail_s2   <= fail_s1;
		end
	end

	// Stage 3: union and single-covered area
	logic [AW-1:0] uni_s3, only_s3;
	logic [PW-1:0] inter_s3;
	logic          zero_s3, novl_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			uni_s3   <= AW'(area_a_s2) + AW'(area_t_s2) - AW'(inter_s2);
			only_s3  <= AW'(area_a_s2) + AW'(area_t_s2) - AW'({inter_s2, 1'b0});
			inter_s3 <= inter_s2;
			novl_s3  <= (inter_s2 == '0);
			zero_s3  <= fail_s2 || (inter_s2 == '0);
		end
	end

	// Stage 4: background clamped at zero
	logic [AW-1:0] uni_s4, only_s4, bg_s4;
	logic [PW-1:0] inter_s4;
	logic          zero_s4, novl_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			bg_s4    <= (frame_area_q > uni_s3) ? frame_area_q - uni_s3 : '0;
			uni_s4   <= uni_s3;
			only_s4  <= only_s3;
			inter_s4 <= inter_s3;
			zero_s4  <= zero_s3;
			novl_s4  <= novl_s3;
		end
	end

	// Stage 5: background plus single-covered area
	logic [AW-1:0] uni_s5, bg_s5;
	logic [BW-1:0] bs_s5;
	logic [PW-1:0] inter_s5;
	logic          zero_s5, novl_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			bs_s5    <= BW'(bg_s4) + BW'(only_s4);
			bg_s5    <= bg_s4;
			uni_s5   <= uni_s4;
			inter_s5 <= inter_s4;
			zero_s5  <= zero_s4;
			novl_s5  <= novl_s4;
		end
	end

	// Stage 6: products
	logic [2*BW-1:0] p_ui_s6, p_bb_s6, p_uu_s6, p_ss_s6;
	logic [AW-1:0]   uni_s6;
	logic [PW-1:0]   inter_s6;
	logic            zero_s6, novl_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			p_ui_s6  <= BW'(uni_s5) * BW'(inter_s5);
			p_bb_s6  <= bs_s5 * BW'(bg_s5);
			p_uu_s6  <= BW'(uni_s5) * BW'(uni_s5);
			p_ss_s6  <= bs_s5 * bs_s5;
			uni_s6   <= uni_s5;
			inter_s6 <= inter_s5;
			zero_s6  <= zero_s5;
			novl_s6  <= novl_s5;
		end
	end

	// Stage 7: numerators and denominators; force 0/1 for zero scores
	logic [DW-1:0] num_s7 [NL];
	logic [DW-1:0] den_s7 [NL];
	logic          novl_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			novl_s7 <= novl_s6;
			if (zero_s6) begin
				num_s7[biou_pkg::LANE_PLAIN] <= '0;
				den_s7[biou_pkg::LANE_PLAIN] <= DW'(1);
				num_s7[biou_pkg::LANE_UNB]   <= '0;
				den_s7[biou_pkg::LANE_UNB]   <= DW'(1);
			end else begin
				num_s7[biou_pkg::LANE_PLAIN] <= DW'(inter_s6);
				den_s7[biou_pkg::LANE_PLAIN] <= DW'(uni_s6);
				num_s7[biou_pkg::LANE_UNB]   <= DW'(p_ui_s6) + DW'(p_bb_s6);
				den_s7[biou_pkg::LANE_UNB]   <= DW'(p_uu_s6) + DW'(p_ss_s6);
			end
		end
	end

	// Division stages: one restoring step per stage, one quotient bit each
	logic [DW-1:0] rem_sd [NL][NS];
	logic [DW-1:0] dvs_sd [NL][NS];
	logic [QW-1:0] quo_sd [NL][NS];
	logic [NS-1:0] novl_sd;
	logic [DW-1:0] rem_nx [NL][NS];
	logic [DW-1:0] dvs_in [NL][NS];
	logic [QW-1:0] quo_nx [NL][NS];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			for (int k = 0; k < NS; k++) begin
				logic [DW:0] rin;
				logic [DW:0] diff;
				logic        ge;
				if (k == 0) begin
					rin       = {1'b0, num_s7[l]};
					dvs_in[l][k] = den_s7[l];
				end else begin
					rin       = {rem_sd[l][k-1], 1'b0};
					dvs_in[l][k] = dvs_sd[l][k-1];
				end
				diff = rin - {1'b0, dvs_in[l][k]};
				ge   = (rin >= {1'b0, dvs_in[l][k]});
				rem_nx[l][k] = ge ? diff[DW-1:0] : rin[DW-1:0];
				if (k == 0) begin
					quo_nx[l][k] = QW'(ge);
				end else begin
					quo_nx[l][k] = {quo_sd[l][k-1][QW-2:0], ge};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			novl_sd <= {novl_sd[NS-2:0], novl_s7};
			for (int l = 0; l < NL; l++) begin
				for (int k = 0; k < NS; k++) begin
					rem_sd[l][k] <= rem_nx[l][k];
					dvs_sd[l][k] <= dvs_in[l][k];
					quo_sd[l][k] <= quo_nx[l][k];
				end
			end
		end
	end

	// Drive the result channel from the last division stage
	assign scores.valid        = vld_sd[NS-1];
	assign scores.plain_iou    = quo_sd[biou_pkg::LANE_PLAIN][NS-1];
	assign scores.unbiased_iou = quo_sd[biou_pkg::LANE_UNB][NS-1];
	assign scores.no_overlap   = novl_sd[NS-1];

	// Checks
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(scores.valid && !scores.ready) |-> !boxes.ready)
		else $error("input taken while output stalled");
	a_plain_range: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid |-> (scores.plain_iou <= (QW'(1) << biou_pkg::FRAC_BITS)))
		else $error("plain score above one");
	a_unb_range: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid |-> (scores.unbiased_iou <= (QW'(1) << biou_pkg::FRAC_BITS)))
		else $error("unbiased score above one");
	a_overlap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(scores.valid && scores.no_overlap) |->
		(scores.plain_iou == '0 && scores.unbiased_iou == '0))
		else $error("nonzero score without overlap");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(scores.valid && !scores.ready) |=> (scores.valid && $stable(scores.plain_iou)))
		else $error("stalled result changed");
endmodule
